// ----- design/gtfb_pkg.sv -----
// Package for the gammatone filterbank: types, constants and the saturating
// fixed-point helper used by the multiplier and the section core.
// Depends on nothing.
`timescale 1ns / 1ps
package gtfb_pkg;
  localparam int unsigned OP_W = 2;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned BAND_W = 6;
  localparam int unsigned OUT_W = 32;
  localparam int unsigned ST_W = 48;
  localparam int unsigned STAGES = 4;
  localparam int unsigned SLOTS = 14;
  localparam int unsigned SLOT_A1 = 12;
  localparam int unsigned SLOT_A2 = 13;
  // Audio sample width; the signal carries 24 fraction bits.
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CIN_W = 32;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef logic signed [ST_W-1:0] st_t;

  // Input request and band output request payloads.
  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BAND_W-1:0]          band_select;
    logic [SLOT_W-1:0]          coeff_slot;
    logic signed [CIN_W-1:0]    coeff_value;
  } req_t;

  typedef struct packed {
    logic [BAND_W-1:0]       band_index;
    logic signed [OUT_W-1:0] band_value;
    logic                    last_band;
  } rsp_t;

  // Saturate a wide signed value to 48 bits.
  function automatic st_t sat48(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sh7FFFFFFFFFFF;
    lo = -72'sh800000000000;
    if (v > hi) sat48 = hi[ST_W-1:0];
    else if (v < lo) sat48 = lo[ST_W-1:0];
    else sat48 = v[ST_W-1:0];
  endfunction
endpackage

// ----- design/gtfb_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface gtfb_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/gtfb_mul.sv -----
// Registered coefficient-times-signal product with floor shift and 48-bit
// saturation. Split into partial products of at most 32x32 bits.
// Depends on gtfb_pkg.
`timescale 1ns / 1ps
module gtfb_mul
  import gtfb_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic signed [COEF_WIDTH-1:0] coef_i,
  input  st_t                          sig_i,
  output st_t                          prod_o
);
  localparam int unsigned FRAC = COEF_WIDTH - 4;
  localparam int unsigned PW = COEF_WIDTH + ST_W;

  logic signed [COEF_WIDTH+24:0] hi_q;
  logic        [COEF_WIDTH+24:0] lo_q;
  logic signed [PW-1:0] full;
  logic signed [PW-1:0] shr;
  st_t prod_q;

  // Stage one: signed high half and unsigned low 24 bits of the signal.
  always_ff @(posedge clk_i) begin
    hi_q <= (COEF_WIDTH+25)'(coef_i * $signed(sig_i[ST_W-1:24]));
    lo_q <= (COEF_WIDTH+25)'($signed(coef_i) * $signed({1'b0, sig_i[23:0]}));
  end

  // Stage two: combine, floor shift (arithmetic), saturate into a register.
  always_comb begin
    full = (PW'(hi_q) <<< 24) + PW'($signed(lo_q));
    shr = full >>> FRAC;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sat48(72'(shr));
  end

  assign prod_o = prod_q;
endmodule

// ----- design/gtfb_core.sv -----
// One biquad section step: y = b0*x+s0, s0' = b1*x+s1-a1*y, s1' = b2*x-a2*y.
// Runs on one shared multiplier. Depends on gtfb_pkg, gtfb_mul.
`timescale 1ns / 1ps
module gtfb_core
  import gtfb_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  st_t                          x_i,
  input  st_t                          s0_i,
  input  st_t                          s1_i,
  input  logic signed [COEF_WIDTH-1:0] b0_i,
  input  logic signed [COEF_WIDTH-1:0] b1_i,
  input  logic signed [COEF_WIDTH-1:0] b2_i,
  input  logic signed [COEF_WIDTH-1:0] a1_i,
  input  logic signed [COEF_WIDTH-1:0] a2_i,
  output logic                         done_o,
  output st_t                          y_o,
  output st_t                          s0_o,
  output st_t                          s1_o
);
  logic [2:0] step_q, step_d;
  logic       busy_q, busy_d;
  st_t y_q, y_d, p1_q, p1_d, p2_q, p2_d, s0n_q, s0n_d;
  st_t s1n_q, s1n_d;
  logic signed [COEF_WIDTH-1:0] mc;
  st_t ms, prod;

  gtfb_mul #(.COEF_WIDTH(COEF_WIDTH)) u_mul (
    .clk_i(clk_i), .coef_i(mc), .sig_i(ms), .prod_o(prod)
  );

  // Issue schedule: 0 b0*x, 1 b1*x, 2 b2*x; y ready at 2; 3 a1*y, 4 a2*y.
  always_comb begin
    mc = b0_i;
    ms = x_i;
    case (step_q)
      3'd0: begin mc = b0_i; ms = x_i; end
      3'd1: begin mc = b1_i; ms = x_i; end
      3'd2: begin mc = b2_i; ms = x_i; end
      3'd3: begin mc = a1_i; ms = y_d; end
      3'd4: begin mc = a2_i; ms = y_q; end
      default: begin mc = b0_i; ms = x_i; end
    endcase
  end

  // Accumulate each product as it leaves the multiplier's output register.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    y_d = y_q; p1_d = p1_q; p2_d = p2_q; s0n_d = s0n_q; s1n_d = s1n_q;
    done_o = 1'b0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = 3'd0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      case (step_q)
        3'd2: y_d = sat48(72'(prod) + 72'(s0_i));
        3'd3: p1_d = prod;
        3'd4: p2_d = prod;
        3'd5: s0n_d = sat48(72'(p1_q) + 72'(s1_i) - 72'(prod));
        3'd6: begin
          s1n_d = sat48(72'(p2_q) - 72'(prod));
          busy_d = 1'b0;
          done_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d; p1_q <= p1_d; p2_q <= p2_d; s0n_q <= s0n_d; s1n_q <= s1n_d;
  end

  assign y_o = y_q;
  assign s0_o = s0n_d;
  assign s1_o = s1n_d;
endmodule

// ----- design/gammatone_filterbank_top.sv -----
// Gammatone filterbank top level: coefficient and delay memories, sequencer.
// Depends on gtfb_pkg, gtfb_if, gtfb_core.
//
//  channel   | dir | payload
//  in_req    | in  | op, sample, band_select, coeff_slot, coeff_value
//  out_req   | out | band_index, band_value, last_band
//
// A filter request is taken while idle. Each section then loads its
// coefficients and state one word a cycle and runs on the shared
// multiplier; each band holds its output until it is taken. A coefficient
// write or an unused op is taken while idle and starts no pass. After
// reset and on a clear request a pass zeroes all BAND_CNT*8 words of the
// delay memory; no request is taken meanwhile. Output stalls hold the
// sequencer.
`timescale 1ns / 1ps
module gammatone_filterbank_top
  import gtfb_pkg::*;
#(
  parameter int unsigned BAND_CNT = 32,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  gtfb_if.sink   in_req,
  gtfb_if.source out_req
);
  localparam int unsigned CDEPTH = BAND_CNT * SLOTS;
  localparam int unsigned SDEPTH = BAND_CNT * STAGES * 2;
  localparam int unsigned CA_W = $clog2(CDEPTH);
  localparam int unsigned SA_W = $clog2(SDEPTH);
  localparam int unsigned BIDX_W = (BAND_CNT > 1) ? $clog2(BAND_CNT) : 1;

  logic signed [COEF_WIDTH-1:0] cmem [CDEPTH];
  st_t smem [SDEPTH];

  state_e state_q, state_d;
  logic [BIDX_W-1:0] band_q, band_d;
  logic [1:0] stage_q, stage_d;
  logic [3:0] ld_q, ld_d;
  logic [SA_W:0] clr_q, clr_d;
  logic core_start, core_done;
  st_t x_q, x_d, xin_q, xin_d, s0r_q, s1r_q, y, s0n, s1n;
  logic signed [COEF_WIDTH-1:0] b0_q, b1_q, b2_q, a1_q, a2_q, crd_q;
  st_t srd_q;
  logic [CA_W-1:0] craddr;
  logic [SA_W-1:0] sraddr, swaddr;
  logic swe, cwe;
  st_t swdat;
  logic [SA_W-1:0] sbase;
  logic [CA_W-1:0] cbase;
  logic [3:0] ld_prev_q;
  logic [OUT_W-1:0] ov_q, ov_d;
  logic [BAND_W-1:0] ob_q, ob_d;
  logic ol_q, ol_d;
  logic wb_q, wb_d;
  logic [SA_W-1:0] sbase_prev_q;
  st_t s1_hold_q;
  st_t sx;
  op_e op;

  assign op = op_e'(in_req.data.op);
  assign sbase = SA_W'((32'(band_q) * STAGES + 32'(stage_q)) * 2);
  assign cbase = CA_W'(32'(band_q) * SLOTS);
  assign sx = st_t'($signed(in_req.data.sample)) <<< (25 - SAMPLE_W);

  // Memory ports: one read and one write each, read data registered.
  always_ff @(posedge clk_i) begin
    crd_q <= cmem[craddr];
    srd_q <= smem[sraddr];
    if (cwe)
      cmem[CA_W'(32'(in_req.data.band_select) * SLOTS + 32'(in_req.data.coeff_slot))]
        <= COEF_WIDTH'(in_req.data.coeff_value);
    if (swe) smem[swaddr] <= swdat;
  end

  // Load order: a1, a2, b0, b1, b2, s0, s1 (each word is taken from the registered read data).
  always_comb begin
    craddr = cbase + CA_W'(SLOT_A1);
    sraddr = sbase;
    case (ld_q)
      4'd0: craddr = cbase + CA_W'(SLOT_A1);
      4'd1: craddr = cbase + CA_W'(SLOT_A2);
      4'd2: craddr = cbase + CA_W'(32'(stage_q) * 3);
      4'd3: craddr = cbase + CA_W'(32'(stage_q) * 3 + 1);
      4'd4: craddr = cbase + CA_W'(32'(stage_q) * 3 + 2);
      4'd5: sraddr = sbase;
      4'd6: sraddr = sbase + SA_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ld_prev_q <= ld_q;
    if (state_q == ST_LOAD) begin
      case (ld_prev_q)
        4'd0: a1_q <= crd_q;
        4'd1: a2_q <= crd_q;
        4'd2: b0_q <= crd_q;
        4'd3: b1_q <= crd_q;
        4'd4: b2_q <= crd_q;
        4'd5: s0r_q <= srd_q;
        4'd6: s1r_q <= srd_q;
        default: ;
      endcase
    end
  end

  // Section datapath; its operands stay steady while it runs.
  gtfb_core #(.COEF_WIDTH(COEF_WIDTH)) u_core (
    .clk_i, .rst_ni, .start_i(core_start), .x_i(x_q), .s0_i(s0r_q), .s1_i(s1r_q),
    .b0_i(b0_q), .b1_i(b1_q), .b2_i(b2_q), .a1_i(a1_q), .a2_i(a2_q),
    .done_o(core_done), .y_o(y), .s0_o(s0n), .s1_o(s1n)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    band_d = band_q; stage_d = stage_q; ld_d = ld_q; clr_d = clr_q;
    x_d = x_q; xin_d = xin_q; wb_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (SA_W+1)'(SDEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          if (op == OP_CLEAR) begin
            state_d = ST_CLEAR; clr_d = '0;
          end else if (op == OP_FILTER) begin
            state_d = ST_LOAD; band_d = '0; stage_d = '0; ld_d = '0;
            x_d = sx; xin_d = sx;
          end
        end
      end
      ST_LOAD: begin
        ld_d = ld_q + 4'd1;
        if (ld_q == 4'd7) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (core_done) begin
          // The section output feeds the next section.
          wb_d = 1'b1;
          x_d = y;
          ld_d = '0;
          if (stage_q == 2'd3) state_d = ST_OUT;
          else begin
            stage_d = stage_q + 2'd1; state_d = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (out_req.ready) begin
          stage_d = '0; ld_d = '0;
          x_d = xin_q;
          if (32'(band_q) == BAND_CNT - 1) state_d = ST_IDLE;
          else begin band_d = band_q + 1'b1; state_d = ST_LOAD; end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory writes.
  always_comb begin
    in_req.ready = (state_q == ST_IDLE);
    core_start = (state_q == ST_LOAD) && (ld_q == 4'd7);
    cwe = (state_q == ST_IDLE) && in_req.valid && (op == OP_WRITE) &&
          (32'(in_req.data.band_select) < BAND_CNT) &&
          (32'(in_req.data.coeff_slot) < SLOTS);
    swe = 1'b0; swaddr = sbase; swdat = s0n;
    if (state_q == ST_CLEAR) begin
      swe = 1'b1; swaddr = clr_q[SA_W-1:0]; swdat = '0;
    end else if (core_done) begin
      swe = 1'b1; swaddr = sbase; swdat = s0n;
    end else if (wb_q) begin
      swe = 1'b1; swaddr = sbase_prev_q + SA_W'(1); swdat = s1_hold_q;
    end
    out_req.valid = (state_q == ST_OUT);
    out_req.data.band_index = ob_q;
    out_req.data.band_value = ov_q;
    out_req.data.last_band = ol_q;
  end

  // The second state word is written back the cycle after the first.
  always_ff @(posedge clk_i) begin
    sbase_prev_q <= sbase;
    s1_hold_q <= s1n;
  end

  // Output word, formed on the last section's completion.
  always_comb begin
    ov_d = ov_q; ob_d = ob_q; ol_d = ol_q;
    if (state_q == ST_RUN && core_done && stage_q == 2'd3) begin
      if (y > st_t'(48'sh7FFFFFFF)) ov_d = 32'h7FFFFFFF;
      else if (y < -st_t'(48'sh80000000)) ov_d = 32'h80000000;
      else ov_d = y[OUT_W-1:0];
      ob_d = BAND_W'(band_q);
      ol_d = (32'(band_q) == BAND_CNT - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; xin_q <= xin_d; ov_q <= ov_d; ob_q <= ob_d; ol_q <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      band_q <= '0; stage_q <= '0; ld_q <= '0; clr_q <= '0; wb_q <= 1'b0;
    end else begin
      state_q <= state_d;
      band_q <= band_d; stage_q <= stage_d; ld_q <= ld_d; clr_q <= clr_d;
      wb_q <= wb_d;
    end
  end
endmodule
